// ===== design/sdm_pkg.sv =====
// Shared constants, types and arithmetic helpers of the sky dome point generator.
`default_nettype none
package sdm_pkg;

  // Fraction-of-turn angle width
  localparam int ANGLE_BITS = 16;
  // Long-division width: covers every numerator the front end builds
  localparam int DIV_W = (ANGLE_BITS + 11 > 27) ? ANGLE_BITS + 11 : 27;
  localparam int TRIG_LAT = 13;
  localparam int TEX_LAT = TRIG_LAT + 2;
  localparam int BACK_LAT = DIV_W + TRIG_LAT + 2;
  // Queue depth, a power of two
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  // Register indexes
  localparam logic [2:0] CFG_HRES = 3'd0;
  localparam logic [2:0] CFG_VRES = 3'd1;
  localparam logic [2:0] CFG_TEXF = 3'd2;
  localparam logic [2:0] CFG_SPHF = 3'd3;
  localparam logic [2:0] CFG_RAD  = 3'd4;

  // Reciprocals for constant division, scaled by 2^34
  localparam logic [63:0] TWO_34 = 64'h4_0000_0000;
  localparam logic [31:0] RCP_42 = 32'(TWO_34 / 42);
  localparam logic [31:0] RCP_20 = 32'(TWO_34 / 20);
  localparam logic [31:0] RCP_6  = 32'(TWO_34 / 6);
  localparam logic [31:0] RCP_56 = 32'(TWO_34 / 56);
  localparam logic [31:0] RCP_30 = 32'(TWO_34 / 30);
  localparam logic [31:0] RCP_12 = 32'(TWO_34 / 12);

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  typedef struct packed {
    logic [10:0] hres;
    logic [10:0] vres;
    logic [15:0] texf;
    logic [16:0] sphf;
    logic [23:0] radius;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cnt;
    logic [15:0] fa;
    logic [15:0] fb;
    logic [15:0] fc;
    logic [15:0] sa;
    logic [15:0] sb;
    logic [15:0] sc;
  } tri_t;

  typedef struct packed {
    logic [DIV_W-1:0] num_az;
    logic [DIV_W-1:0] num_el;
    logic [DIV_W-1:0] num_tu;
    logic [DIV_W-1:0] num_tv;
    tri_t             tris;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Zero resolution acts as one
  function automatic logic [10:0] eff_res(input logic [10:0] r);
    return (r == 11'd0) ? 11'd1 : r;
  endfunction

  // Estimate of y / c, low by at most one
  function automatic logic [30:0] rcp_hi(input logic [30:0] y, input logic [31:0] m);
    return 31'((64'(y) * 64'(m)) >> 34);
  endfunction

  // Correct the estimate by one compare and subtract
  function automatic logic [30:0] rcp_fix(input logic [30:0] y, input logic [30:0] q0,
                                          input logic [5:0] c);
    logic [30:0] r;
    r = y - 31'(q0 * 31'(c));
    return (r >= 31'(c)) ? q0 + 31'd1 : q0;
  endfunction

  // Q30 product rounded half away from zero
  function automatic logic signed [24:0] mul_round(input logic signed [24:0] a,
                                                   input logic signed [31:0] b);
    logic        neg;
    logic [24:0] ua;
    logic [31:0] ub;
    logic [56:0] p;
    logic [25:0] mag;
    neg = a[24] ^ b[31];
    ua  = a[24] ? 25'(-a) : 25'(a);
    ub  = b[31] ? 32'(-b) : 32'(b);
    p   = 57'(ua) * 57'(ub) + (57'(1) << 29);
    mag = 26'(p >> 30);
    return neg ? 25'(26'd0 - mag) : 25'(mag);
  endfunction

endpackage
`default_nettype wire

// ===== design/sdm_fifo.sv =====
// Short word queue between the front and back ends.
`default_nettype none
module sdm_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  sdm_pkg::item_t          wdata,
  input  logic                    pop,
  output sdm_pkg::item_t          rdata,
  output sdm_pkg::fifo_stat_t     stat
);
  import sdm_pkg::*;

  item_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;

  assign rdata      = mem_r[rp_r];
  assign stat.full  = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the word
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !stat.full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !stat.empty)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
      cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

// ===== design/sdm_front.sv =====
// Front end: takes grid points, builds divider numerators and triangle indices.
`default_nettype none
module sdm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [10:0]         in_column,
  input  logic [10:0]         in_row,
  input  sdm_pkg::cfg_t       cfg,
  input  sdm_pkg::fifo_stat_t fstat,
  output logic                push,
  output sdm_pkg::item_t      item
);
  import sdm_pkg::*;

  logic        valid_r, valid_nxt;
  logic [10:0] col_r, row_r;
  logic [10:0] h, v;
  logic [16:0] s_abs;
  logic [15:0] s;
  logic [26:0] js;
  logic [ANGLE_BITS+27:0] el_pre;
  logic [15:0] base;

  assign in_stall  = valid_r && fstat.full;
  assign push      = valid_r && !fstat.full;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  // Hold the point while the queue is full
  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      col_r <= in_column;
      row_r <= in_row;
    end
  end

  // Numerators for the four long divisions
  always_comb begin
    h      = eff_res(cfg.hres);
    v      = eff_res(cfg.vres);
    s_abs  = cfg.sphf[16] ? 17'(18'h20000 - 18'(cfg.sphf)) : cfg.sphf;
    s      = (s_abs > 17'd32768) ? 16'd32768 : s_abs[15:0];
    js     = 27'(row_r) * 27'(s);
    el_pre = ((ANGLE_BITS+28)'(js) << ANGLE_BITS) + ((ANGLE_BITS+28)'(v) << 15);
    item.num_az = (DIV_W'(col_r) << ANGLE_BITS) + DIV_W'(h >> 1);
    item.num_el = DIV_W'(el_pre >> 16);
    item.num_tu = (DIV_W'(col_r) << 15) + DIV_W'(h >> 1);
    item.num_tv = DIV_W'(row_r) * DIV_W'(cfg.texf) + DIV_W'(v >> 1);
  end

  // Classify the cell and form its indices
  always_comb begin
    base = 16'(23'(12'(v) + 12'd1) * 23'(col_r) + 23'(row_r));
    item.tris = '0;
    if (col_r < h && row_r < v) begin
      item.tris.fa  = 16'(base + 16'(v) + 16'd2);
      item.tris.fb  = base + 16'd1;
      item.tris.fc  = base;
      item.tris.cnt = 2'd1;
      if (row_r != 11'd0) begin
        item.tris.cnt = 2'd2;
        item.tris.sa  = 16'(base + 16'(v) + 16'd1);
        item.tris.sb  = 16'(base + 16'(v) + 16'd2);
        item.tris.sc  = base;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/sdm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module sdm_div (
  input  logic                     clk,
  input  logic                     en,
  input  logic [sdm_pkg::DIV_W-1:0] num,
  input  logic [10:0]              den,
  output logic [sdm_pkg::DIV_W-1:0] quo
);
  import sdm_pkg::*;

  // Each word is {remainder, numerator bits left and quotient bits so far}
  logic [DIV_W+10:0] w_r [DIV_W];

  function automatic logic [DIV_W+10:0] step(input logic [DIV_W+10:0] w,
                                             input logic [10:0] d);
    logic [11:0] cand;
    logic        ge;
    logic [10:0] nrem;
    cand = {w[DIV_W+10:DIV_W], w[DIV_W-1]};
    ge   = (cand >= {1'b0, d});
    nrem = ge ? 11'(cand - {1'b0, d}) : cand[10:0];
    return {nrem, w[DIV_W-2:0], ge};
  endfunction

  // Advance one bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      w_r[0] <= step({11'd0, num}, den);
      for (int i = 1; i < DIV_W; i++) w_r[i] <= step(w_r[i-1], den);
    end
  end

  assign quo = w_r[DIV_W-1][DIV_W-1:0];

endmodule
`default_nettype wire

// ===== design/sdm_trig.sv =====
// Pipelined sine and cosine of a fraction-of-turn angle, Q30 results.
`default_nettype none
module sdm_trig (
  input  logic                          clk,
  input  logic                          en,
  input  logic [sdm_pkg::ANGLE_BITS-1:0] angle,
  output logic signed [31:0]            sn,
  output logic signed [31:0]            cs
);
  import sdm_pkg::*;

  logic [31:0] aw, tq, rr;
  logic [1:0]  qd;
  logic        ng;
  logic [29:0] mm;

  logic [29:0] m1_r;
  logic [1:0]  q_r   [1:12];
  logic        neg_r [1:12];
  logic [29:0] x_r   [2:11];
  logic [29:0] x2_r  [3:11];
  logic [30:0] sq4_r, st5_r, sp6_r, sq7_r, sy7_r, st8_r, sp9_r, sq10_r, sy10_r, st11_r, s12_r;
  logic [30:0] cq4_r, ct5_r, cp6_r, cq7_r, cy7_r, ct8_r, cp9_r, cq10_r, cy10_r, ct11_r, c12_r;
  logic [30:0] cp12;
  logic signed [31:0] s_sg, c_sg;
  logic signed [31:0] sn_r, cs_r;

  // Reduce to the nearest quadrant
  always_comb begin
    aw = 32'(angle) << (32 - ANGLE_BITS);
    tq = aw + 32'h2000_0000;
    qd = tq[31:30];
    rr = aw - {qd, 30'd0};
    ng = rr[31];
    mm = ng ? 30'(32'd0 - rr) : 30'(rr);
  end

  assign cp12 = 31'((62'(x2_r[11]) * 62'(ct11_r)) >> 30);
  assign s_sg = neg_r[12] ? -$signed({1'b0, s12_r}) : $signed({1'b0, s12_r});
  assign c_sg = $signed({1'b0, c12_r});

  always_ff @(posedge clk) begin
    if (en) begin
      // Radians and square
      m1_r     <= mm;
      q_r[1]   <= qd;
      neg_r[1] <= ng;
      for (int i = 2; i <= 12; i++) begin
        q_r[i]   <= q_r[i-1];
        neg_r[i] <= neg_r[i-1];
      end
      x_r[2]  <= 30'((64'(m1_r) * 64'd1686629713 + 64'd536870912) >> 30);
      for (int i = 3; i <= 11; i++) x_r[i] <= x_r[i-1];
      x2_r[3] <= 30'((60'(x_r[2]) * 60'(x_r[2]) + 60'd536870912) >> 30);
      for (int i = 4; i <= 11; i++) x2_r[i] <= x2_r[i-1];
      // Horner steps, sine lane
      sq4_r  <= rcp_hi(31'(x2_r[3]), RCP_42);
      st5_r  <= ONE_Q30 - rcp_fix(31'(x2_r[4]), sq4_r, 6'd42);
      sp6_r  <= 31'((62'(x2_r[5]) * 62'(st5_r)) >> 30);
      sq7_r  <= rcp_hi(sp6_r, RCP_20);
      sy7_r  <= sp6_r;
      st8_r  <= ONE_Q30 - rcp_fix(sy7_r, sq7_r, 6'd20);
      sp9_r  <= 31'((62'(x2_r[8]) * 62'(st8_r)) >> 30);
      sq10_r <= rcp_hi(sp9_r, RCP_6);
      sy10_r <= sp9_r;
      st11_r <= ONE_Q30 - rcp_fix(sy10_r, sq10_r, 6'd6);
      s12_r  <= 31'((62'(x_r[11]) * 62'(st11_r)) >> 30);
      // Horner steps, cosine lane
      cq4_r  <= rcp_hi(31'(x2_r[3]), RCP_56);
      ct5_r  <= ONE_Q30 - rcp_fix(31'(x2_r[4]), cq4_r, 6'd56);
      cp6_r  <= 31'((62'(x2_r[5]) * 62'(ct5_r)) >> 30);
      cq7_r  <= rcp_hi(cp6_r, RCP_30);
      cy7_r  <= cp6_r;
      ct8_r  <= ONE_Q30 - rcp_fix(cy7_r, cq7_r, 6'd30);
      cp9_r  <= 31'((62'(x2_r[8]) * 62'(ct8_r)) >> 30);
      cq10_r <= rcp_hi(cp9_r, RCP_12);
      cy10_r <= cp9_r;
      ct11_r <= ONE_Q30 - rcp_fix(cy10_r, cq10_r, 6'd12);
      c12_r  <= ONE_Q30 - (cp12 >> 1);
      // Place by quadrant
      case (q_r[12])
        2'd0: begin sn_r <= s_sg;  cs_r <= c_sg;  end
        2'd1: begin sn_r <= c_sg;  cs_r <= -s_sg; end
        2'd2: begin sn_r <= -s_sg; cs_r <= -c_sg; end
        default: begin sn_r <= -c_sg; cs_r <= s_sg; end
      endcase
    end
  end

  assign sn = sn_r;
  assign cs = cs_r;

endmodule
`default_nettype wire

// ===== design/sdm_back.sv =====
// Back end: divisions, trigonometry, scaling and the result register.
`default_nettype none
module sdm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  sdm_pkg::cfg_t       cfg,
  input  sdm_pkg::fifo_stat_t fstat,
  input  sdm_pkg::item_t      item,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [24:0]  out_pos_x,
  output logic signed [24:0]  out_pos_y,
  output logic signed [24:0]  out_pos_z,
  output logic [15:0]         out_tex_u,
  output logic [15:0]         out_tex_v,
  output sdm_pkg::tri_t       out_tri
);
  import sdm_pkg::*;

  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  logic                  en;
  logic [10:0]           h, v;
  logic [DIV_W-1:0]      q_az, q_el, q_tu, q_tv;
  logic [ANGLE_BITS-1:0] az, el;
  logic signed [31:0]    sa, ca, se, cE;
  logic                  vld_r [BACK_LAT];
  tri_t                  tri_r [BACK_LAT];
  logic [15:0]           tu_r  [TEX_LAT];
  logic [15:0]           tv_r  [TEX_LAT];
  logic signed [24:0]    ce_r, py_r, px_r, pz_r;
  logic signed [31:0]    sa_r, ca_r;
  logic signed [24:0]    rad_s;

  function automatic logic [15:0] sat16(input logic [DIV_W-1:0] q);
    return (q > DIV_W'(16'hFFFF)) ? 16'hFFFF : q[15:0];
  endfunction

  // Move the whole pipeline unless the result waits
  assign en  = !(vld_r[BACK_LAT-1] && out_stall);
  assign pop = en && !fstat.empty;
  assign h   = eff_res(cfg.hres);
  assign v   = eff_res(cfg.vres);

  sdm_div u_div_az (.clk(clk), .en(en), .num(item.num_az), .den(h), .quo(q_az));
  sdm_div u_div_el (.clk(clk), .en(en), .num(item.num_el), .den(v), .quo(q_el));
  sdm_div u_div_tu (.clk(clk), .en(en), .num(item.num_tu), .den(h), .quo(q_tu));
  sdm_div u_div_tv (.clk(clk), .en(en), .num(item.num_tv), .den(v), .quo(q_tv));

  assign az = q_az[ANGLE_BITS-1:0];
  assign el = QUARTER - q_el[ANGLE_BITS-1:0];

  sdm_trig u_trig_az (.clk(clk), .en(en), .angle(az), .sn(sa), .cs(ca));
  sdm_trig u_trig_el (.clk(clk), .en(en), .angle(el), .sn(se), .cs(cE));

  assign rad_s = $signed({1'b0, cfg.radius});

  // Track valid words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BACK_LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= pop;
      for (int i = 1; i < BACK_LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // Delay side data and scale the position
  always_ff @(posedge clk) begin
    if (en) begin
      tri_r[0] <= item.tris;
      for (int i = 1; i < BACK_LAT; i++) tri_r[i] <= tri_r[i-1];
      tu_r[0] <= sat16(q_tu);
      tv_r[0] <= sat16(q_tv);
      for (int i = 1; i < TEX_LAT; i++) begin
        tu_r[i] <= tu_r[i-1];
        tv_r[i] <= tv_r[i-1];
      end
      ce_r <= mul_round(rad_s, cE);
      py_r <= mul_round(rad_s, se);
      sa_r <= sa;
      ca_r <= ca;
      px_r <= mul_round(ce_r, sa_r);
      pz_r <= mul_round(ce_r, ca_r);
      out_pos_y <= py_r;
    end
  end

  assign out_valid = vld_r[BACK_LAT-1];
  assign out_tri   = tri_r[BACK_LAT-1];
  assign out_tex_u = tu_r[TEX_LAT-1];
  assign out_tex_v = tv_r[TEX_LAT-1];
  assign out_pos_x = px_r;
  assign out_pos_z = pz_r;

  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_tri.cnt == 2'd0 |-> out_tri.fa == 16'd0 && out_tri.sc == 16'd0)
    else $error("absent triangle carries indices");
  a_one_tri: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_tri.cnt == 2'd1 |-> out_tri.sa == 16'd0 && out_tri.sb == 16'd0)
    else $error("second triangle present on first row");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> out_tri.cnt != 2'd3)
    else $error("triangle count out of range");

endmodule
`default_nettype wire

// ===== design/sky_dome_mesh_point_generator.sv =====
// Top level of the sky dome point generator: configuration registers and wiring.
//
//  channel | handshake            | word
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | in_column, in_row
//  out     | out_valid / out_stall| positions, texture coordinates, triangles
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
// One grid point per cycle sustained while the output is not stalled; the divider
// and trig pipelines all advance together. Latency is set by the one-bit-per-stage
// dividers and the 13-stage sine/cosine unit.
// Synchronous active-low reset clears valid state and loads register defaults.
// An output stall freezes the back end; the four-word queue then fills and
// the input stalls.
`default_nettype none
module sky_dome_mesh_point_generator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [10:0]        in_column,
  input  logic [10:0]        in_row,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [24:0] out_pos_x,
  output logic signed [24:0] out_pos_y,
  output logic signed [24:0] out_pos_z,
  output logic [15:0]        out_tex_u,
  output logic [15:0]        out_tex_v,
  output logic [1:0]         out_tri_count,
  output logic [15:0]        out_first_a,
  output logic [15:0]        out_first_b,
  output logic [15:0]        out_first_c,
  output logic [15:0]        out_second_a,
  output logic [15:0]        out_second_b,
  output logic [15:0]        out_second_c,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_wdata
);
  import sdm_pkg::*;

  cfg_t       cfg_r;
  fifo_stat_t fstat;
  item_t      f_item, b_item;
  logic       push, pop;
  tri_t       tri_o;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hres   <= 11'd30;
      cfg_r.vres   <= 11'd8;
      cfg_r.texf   <= 16'd32768;
      cfg_r.sphf   <= 17'd16384;
      cfg_r.radius <= 24'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HRES: cfg_r.hres   <= cfg_wdata[10:0];
        CFG_VRES: cfg_r.vres   <= cfg_wdata[10:0];
        CFG_TEXF: cfg_r.texf   <= cfg_wdata[15:0];
        CFG_SPHF: cfg_r.sphf   <= cfg_wdata[16:0];
        CFG_RAD:  cfg_r.radius <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sdm_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_column(in_column), .in_row(in_row), .cfg(cfg_r), .fstat(fstat),
    .push(push), .item(f_item)
  );

  sdm_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .wdata(f_item), .pop(pop),
    .rdata(b_item), .stat(fstat)
  );

  sdm_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .fstat(fstat), .item(b_item), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_pos_x(out_pos_x),
    .out_pos_y(out_pos_y), .out_pos_z(out_pos_z), .out_tex_u(out_tex_u),
    .out_tex_v(out_tex_v), .out_tri(tri_o)
  );

  assign out_tri_count = tri_o.cnt;
  assign out_first_a   = tri_o.fa;
  assign out_first_b   = tri_o.fb;
  assign out_first_c   = tri_o.fc;
  assign out_second_a  = tri_o.sa;
  assign out_second_b  = tri_o.sb;
  assign out_second_c  = tri_o.sc;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench of the sky dome point generator: directed and random grid points against a predictor.
module tb_top;
  import sdm_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [10:0] in_column = '0;
  logic [10:0] in_row = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [24:0] out_pos_x, out_pos_y, out_pos_z;
  logic [15:0] out_tex_u, out_tex_v;
  logic [1:0] out_tri_count;
  logic [15:0] out_first_a, out_first_b, out_first_c;
  logic [15:0] out_second_a, out_second_b, out_second_c;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_wdata = '0;

  typedef struct packed {
    logic signed [24:0] px, py, pz;
    logic [15:0] tu, tv;
    logic [1:0] cnt;
    logic [15:0] fa, fb, fc, sa, sb, sc;
  } vertex_t;

  vertex_t pending_vertices[$];
  int mismatches = 0;
  int cycles = 0;
  bit rand_gaps = 1'b1;

  // Model copy of the registers
  logic [10:0] m_hres = 11'd30, m_vres = 11'd8;
  logic [15:0] m_texf = 16'd32768;
  logic [16:0] m_sphf = 17'd16384;
  logic [23:0] m_rad = 24'd256;

  sky_dome_mesh_point_generator DUT (.*);

  always #2 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Sine and cosine of a 32-bit turn angle, Q30
  task automatic sincos(input logic [31:0] a, output longint sn, output longint cs);
    longint unsigned one, m, x, x2, t, s0, c0;
    logic [31:0] q, r;
    bit neg;
    longint s;
    one = 64'd1 << 30;
    q = ((a + 32'h2000_0000) >> 30) & 32'd3;
    r = a - (q << 30);
    neg = r >= 32'h8000_0000;
    m = neg ? 64'(32'(0 - r)) : 64'(r);
    x = (m * 64'd1686629713 + (one >> 1)) >> 30;
    x2 = (x * x + (one >> 1)) >> 30;
    t = one - x2 / 42;
    t = one - ((x2 * t) >> 30) / 20;
    t = one - ((x2 * t) >> 30) / 6;
    s0 = (x * t) >> 30;
    t = one - x2 / 56;
    t = one - ((x2 * t) >> 30) / 30;
    t = one - ((x2 * t) >> 30) / 12;
    c0 = one - ((x2 * t) >> 30) / 2;
    s = neg ? -longint'(s0) : longint'(s0);
    case (q)
      0: begin sn = s; cs = longint'(c0); end
      1: begin sn = longint'(c0); cs = -s; end
      2: begin sn = -s; cs = -longint'(c0); end
      default: begin sn = -longint'(c0); cs = s; end
    endcase
  endtask

  function automatic longint q30_product(longint a, longint b);
    bit neg;
    longint unsigned p;
    neg = (a < 0) != (b < 0);
    p = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + (64'd1 << 29)) >> 30;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [15:0] clip16(longint unsigned v);
    return v > 65535 ? 16'hFFFF : v[15:0];
  endfunction

  task automatic predict_vertex(input logic [10:0] k, input logic [10:0] j,
                                output vertex_t e);
    longint unsigned h, v, s, az, el, den, delta, base;
    longint sa, ca, se, cel, ce;
    h = m_hres == 0 ? 1 : m_hres;
    v = m_vres == 0 ? 1 : m_vres;
    s = m_sphf[16] ? 64'h20000 - m_sphf : m_sphf;
    if (s > 32768) s = 32768;
    az = ((64'(k) << ANGLE_BITS) + h / 2) / h;
    den = v << 16;
    delta = ((64'(j) * s << ANGLE_BITS) + den / 2) / den;
    el = (64'd1 << (ANGLE_BITS - 2)) - delta;
    sincos({az[15:0], 16'h0}, sa, ca);
    sincos({el[15:0], 16'h0}, se, cel);
    ce = q30_product(m_rad, cel);
    e.px = 25'(q30_product(ce, sa));
    e.py = 25'(q30_product(m_rad, se));
    e.pz = 25'(q30_product(ce, ca));
    e.tu = clip16((64'(k) * 32768 + h / 2) / h);
    e.tv = clip16((64'(j) * m_texf + v / 2) / v);
    base = ((v + 1) * k + j) & 64'hFFFF;
    {e.cnt, e.fa, e.fb, e.fc, e.sa, e.sb, e.sc} = '0;
    if (k < h && j < v) begin
      e.fa = 16'(base + v + 2);
      e.fb = 16'(base + 1);
      e.fc = 16'(base);
      e.cnt = 2'd1;
      if (j != 0) begin
        e.cnt = 2'd2;
        e.sa = 16'(base + v + 1);
        e.sb = 16'(base + v + 2);
        e.sc = 16'(base);
      end
    end
  endtask

  // Send one grid point and queue its expected word; valid stays up for a follower
  task automatic send_point(input logic [10:0] k, input logic [10:0] j);
    vertex_t e;
    int gap;
    gap = rand_gaps ? $urandom_range(0, 6) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_column <= k;
    in_row <= j;
    do @(posedge clk); while (in_stall);
    predict_vertex(k, j, e);
    pending_vertices.push_back(e);
  endtask

  // Drop valid and wait for every expected word
  task automatic drain;
    @(negedge clk) in_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Write one register while idle
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_HRES: m_hres = val[10:0];
      CFG_VRES: m_vres = val[10:0];
      CFG_TEXF: m_texf = val[15:0];
      CFG_SPHF: m_sphf = val[16:0];
      CFG_RAD:  m_rad  = val;
      default: ;
    endcase
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic set_dome(input int h, input int v, input int tf, input int sf, input int r);
    drain();
    write_reg(CFG_HRES, 24'(h));
    write_reg(CFG_VRES, 24'(v));
    write_reg(CFG_TEXF, 24'(tf));
    write_reg(CFG_SPHF, 24'(sf));
    write_reg(CFG_RAD, 24'(r));
  endtask

  // Grid corners, rows, outside points and field extremes
  task automatic test_directed;
    send_point(0, 0);
    send_point(30, 8);
    send_point(29, 7);
    send_point(5, 0);
    send_point(0, 3);
    send_point(2047, 2047);
    send_point(1024, 0);
    send_point(0, 1024);
    send_point(1365, 682);
    send_point(682, 1365);
    set_dome(0, 0, 65535, 17'h10000, 24'hFFFFFF);
    send_point(0, 0);
    send_point(1, 1);
    send_point(0, 1);
    send_point(2047, 0);
    set_dome(1024, 1024, 0, 17'h0FFFF, 0);
    send_point(1023, 1023);
    send_point(1024, 1024);
    send_point(512, 0);
    send_point(700, 700);
    set_dome(1024, 1024, 32768, 17'h1C000, 24'hABCDEF);
    send_point(1023, 1);
    send_point(63, 1000);
  endtask

  // Mostly in-grid points across random dome settings
  task automatic test_random;
    int h, v;
    for (int blk = 0; blk < 9; blk++) begin
      if (blk % 3 == 0) begin
        h = $urandom_range(1, 1024);
        v = $urandom_range(1, 1024);
      end else begin
        h = $urandom_range(0, 40);
        v = $urandom_range(0, 40);
      end
      set_dome(h, v, $urandom_range(0, 65535), $urandom_range(0, 17'h1FFFF),
               $urandom());
      rand_gaps = blk != 4;
      for (int i = 0; i < 150; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_point(11'($urandom()), 11'($urandom()));
        else
          send_point(11'($urandom_range(0, h)), 11'($urandom_range(0, v)));
      end
    end
    rand_gaps = 1'b1;
  endtask

  // Output stall pattern: random waits, with quiet stretches
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else if (cycles % 2000 < 300) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 6) > 3);
  end

  // Compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    vertex_t got, e;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_pos_x, out_pos_y, out_pos_z, out_tex_u, out_tex_v, out_tri_count,
             out_first_a, out_first_b, out_first_c, out_second_a, out_second_b,
             out_second_c};
      if (pending_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        e = pending_vertices.pop_front();
        if (got !== e) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp pos %0d %0d %0d tex %0d %0d tri %0d %0d %0d %0d %0d %0d %0d",
                     e.px, e.py, e.pz, e.tu, e.tv, e.cnt, e.fa, e.fb, e.fc, e.sa, e.sb, e.sc);
            $display("          got pos %0d %0d %0d tex %0d %0d tri %0d %0d %0d %0d %0d %0d %0d",
                     got.px, got.py, got.pz, got.tu, got.tv, got.cnt, got.fa, got.fb,
                     got.fc, got.sa, got.sb, got.sc);
          end
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_directed();
    // Hold input until everything has come back
    drain();
    test_random();
    drain();
    if (mismatches == 0 && pending_vertices.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
